FILE: hw/rtl/cba_pkg.sv
package cba_pkg;

    localparam int MAX_CHUNKS = 16;
    localparam int IDX_W      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);

    localparam int SIZE_W     = 16;
    localparam int ADDR_W     = 20;
    localparam int BYTES_W    = 17;
    localparam int OFF_W      = 16;

    localparam logic [BYTES_W-1:0] CHUNK_RESET = 17'd4096;
    localparam logic [BYTES_W-1:0] CHUNK_LIMIT = 17'd65536;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // decoded command kinds
    localparam logic [1:0] CMD_BADSIZE = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_FREE    = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
    localparam logic [1:0] ST_NO_CHUNK  = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic              operation;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_addr;
        logic [1:0]        status;
    } rsp_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

FILE: hw/rtl/cba_ram.sv
module cba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/cba_front.sv
module cba_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  cba_pkg::req_t                   req,
    output logic                            busy,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cba_pkg::BYTES_W-1:0]     cfg_data,
    input  cba_pkg::fifo_stat_t             fstat,
    output logic                            push,
    output cba_pkg::cmd_t                   push_cmd,
    output logic [cba_pkg::BYTES_W-1:0]     csize
);

    logic [cba_pkg::BYTES_W-1:0] chunk_bytes_reg;
    logic [cba_pkg::BYTES_W-1:0] chunk_bytes_next;
    logic [cba_pkg::BYTES_W-1:0] half;
    logic                        bad_size;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        chunk_bytes_next = chunk_bytes_reg;
        if (cfg_valid && cfg_ready)
        begin
            chunk_bytes_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_bytes_reg <= cba_pkg::CHUNK_RESET;
        end
        else
        begin
            chunk_bytes_reg <= chunk_bytes_next;
        end
    end

    assign csize = (chunk_bytes_reg > cba_pkg::CHUNK_LIMIT) ? cba_pkg::CHUNK_LIMIT
                                                            : chunk_bytes_reg;
    assign half  = csize >> 1;

    assign bad_size = (req.req_size == '0) || ({1'b0, req.req_size} >= half);

    assign busy = fstat.full;
    assign push = start && !busy;

    always_comb
    begin
        push_cmd.size = req.req_size;
        push_cmd.addr = req.free_addr;
        priority if (bad_size)
        begin
            push_cmd.kind = cba_pkg::CMD_BADSIZE;
        end
        else if (req.operation)
        begin
            push_cmd.kind = cba_pkg::CMD_FREE;
        end
        else
        begin
            push_cmd.kind = cba_pkg::CMD_ALLOC;
        end
    end

endmodule

FILE: hw/rtl/cba_cmd_fifo.sv
module cba_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cba_pkg::cmd_t       push_cmd,
    input  logic                pop,
    output cba_pkg::cmd_t       pop_cmd,
    output cba_pkg::fifo_stat_t fstat
);

    cba_pkg::cmd_t                     slot_reg [cba_pkg::FIFO_DEPTH];
    logic [cba_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [cba_pkg::FIFO_PTR_W-1:0]    wr_ptr_next;
    logic [cba_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [cba_pkg::FIFO_PTR_W-1:0]    rd_ptr_next;
    logic [cba_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic [cba_pkg::FIFO_CNT_W-1:0]    count_next;
    logic                              do_push;
    logic                              do_pop;

    localparam logic [cba_pkg::FIFO_PTR_W-1:0] LAST =
        cba_pkg::FIFO_PTR_W'(cba_pkg::FIFO_DEPTH - 1);
    localparam logic [cba_pkg::FIFO_CNT_W-1:0] FULL_CNT =
        cba_pkg::FIFO_CNT_W'(cba_pkg::FIFO_DEPTH);

    assign fstat.full  = (count_reg == FULL_CNT);
    assign fstat.empty = (count_reg == '0);
    assign do_push     = push && !fstat.full;
    assign do_pop      = pop && !fstat.empty;
    assign pop_cmd     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hw/rtl/cba_back.sv
module cba_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [cba_pkg::BYTES_W-1:0] csize,
    input  cba_pkg::cmd_t               cmd,
    input  cba_pkg::fifo_stat_t         fstat,
    output logic                        pop,
    output logic                        done,
    output cba_pkg::rsp_t               rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_OPEN = 2'd2;
    localparam logic [1:0] S_FREE = 2'd3;

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic [cba_pkg::IDX_W-1:0]     k_reg;
    logic [cba_pkg::IDX_W-1:0]     k_next;
    cba_pkg::cmd_t                 cmd_reg;
    cba_pkg::cmd_t                 cmd_next;
    logic [cba_pkg::CNT_W-1:0]     open_reg;
    logic [cba_pkg::CNT_W-1:0]     open_next;
    logic                          done_reg;
    logic                          done_next;
    cba_pkg::rsp_t                 rsp_reg;
    cba_pkg::rsp_t                 rsp_next;

    logic [cba_pkg::IDX_W-1:0]     raddr;
    logic [cba_pkg::IDX_W-1:0]     waddr;
    logic                          cur_we;
    logic [cba_pkg::BYTES_W-1:0]   cur_wdata;
    logic [cba_pkg::BYTES_W-1:0]   cur_rd;
    logic                          fr_we;
    logic [cba_pkg::BYTES_W-1:0]   fr_wdata;
    logic [cba_pkg::BYTES_W-1:0]   fr_rd;

    logic [cba_pkg::BYTES_W-1:0]   size_ext;
    logic [cba_pkg::BYTES_W-1:0]   off_ext;
    logic [cba_pkg::BYTES_W:0]     fr_sum;
    logic [cba_pkg::BYTES_W-1:0]   fr_sat;
    logic [cba_pkg::BYTES_W-1:0]   new_cur;
    logic [cba_pkg::BYTES_W-1:0]   new_fr;
    logic [3:0]                    in_chunk;
    logic [3:0]                    reg_chunk;

    cba_ram #(.WIDTH(cba_pkg::BYTES_W), .DEPTH(cba_pkg::MAX_CHUNKS)) u_cursor_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (waddr),
        .wdata (cur_wdata),
        .raddr (raddr),
        .rdata (cur_rd)
    );

    cba_ram #(.WIDTH(cba_pkg::BYTES_W), .DEPTH(cba_pkg::MAX_CHUNKS)) u_freed_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (waddr),
        .wdata (fr_wdata),
        .raddr (raddr),
        .rdata (fr_rd)
    );

    assign in_chunk  = cmd.addr[19:16];
    assign reg_chunk = cmd_reg.addr[19:16];
    assign size_ext  = {1'b0, cmd_reg.size};
    assign off_ext   = {1'b0, cmd_reg.addr[cba_pkg::OFF_W-1:0]};

    // out-of-order free: freed count saturates
    assign fr_sum = {1'b0, fr_rd} + {2'b00, cmd_reg.size};
    assign fr_sat = fr_sum[cba_pkg::BYTES_W] ? '1 : fr_sum[cba_pkg::BYTES_W-1:0];

    always_comb
    begin
        if ((size_ext <= cur_rd) && ((cur_rd - size_ext) == off_ext))
        begin
            new_cur = cur_rd - size_ext;
            new_fr  = fr_rd;
        end
        else
        begin
            new_cur = cur_rd;
            new_fr  = fr_sat;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd_next   = cmd_reg;
        open_next  = open_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        pop        = 1'b0;
        raddr      = k_reg;
        waddr      = k_reg;
        cur_we     = 1'b0;
        cur_wdata  = '0;
        fr_we      = 1'b0;
        fr_wdata   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!fstat.empty)
                begin
                    pop      = 1'b1;
                    cmd_next = cmd;
                    unique case (cmd.kind)
                        cba_pkg::CMD_ALLOC:
                        begin
                            if (open_reg == '0)
                            begin
                                state_next = S_OPEN;
                            end
                            else
                            begin
                                k_next     = cba_pkg::IDX_W'(open_reg - 1'b1);
                                raddr      = k_next;
                                state_next = S_SRCH;
                            end
                        end
                        cba_pkg::CMD_FREE:
                        begin
                            if (32'(in_chunk) < 32'(open_reg))
                            begin
                                raddr      = cba_pkg::IDX_W'(in_chunk);
                                state_next = S_FREE;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{alloc_addr: '0, status: cba_pkg::ST_NOT_FOUND};
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{alloc_addr: '0, status: cba_pkg::ST_BAD_SIZE};
                        end
                    endcase
                end
            end

            // cursor of chunk k_reg is on the read port this cycle
            S_SRCH:
            begin
                if ((cur_rd < csize) && ((csize - cur_rd) >= size_ext))
                begin
                    cur_we     = 1'b1;
                    cur_wdata  = cur_rd + size_ext;
                    done_next  = 1'b1;
                    rsp_next   = '{alloc_addr: cba_pkg::ADDR_W'((32'(k_reg) << 16)
                                                                 + 32'(cur_rd)),
                                   status: cba_pkg::ST_OK};
                    state_next = S_IDLE;
                end
                else if (k_reg == '0)
                begin
                    state_next = S_OPEN;
                end
                else
                begin
                    k_next = k_reg - 1'b1;
                    raddr  = k_next;
                end
            end

            S_OPEN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (32'(open_reg) >= 32'(cba_pkg::MAX_CHUNKS))
                begin
                    rsp_next = '{alloc_addr: '0, status: cba_pkg::ST_NO_CHUNK};
                end
                else
                begin
                    waddr     = cba_pkg::IDX_W'(open_reg);
                    cur_we    = 1'b1;
                    cur_wdata = size_ext;
                    fr_we     = 1'b1;
                    fr_wdata  = '0;
                    open_next = open_reg + 1'b1;
                    rsp_next  = '{alloc_addr: cba_pkg::ADDR_W'(32'(open_reg) << 16),
                                  status: cba_pkg::ST_OK};
                end
            end

            S_FREE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (off_ext >= cur_rd)
                begin
                    rsp_next = '{alloc_addr: '0, status: cba_pkg::ST_NOT_FOUND};
                end
                else
                begin
                    waddr    = cba_pkg::IDX_W'(reg_chunk);
                    cur_we   = 1'b1;
                    fr_we    = 1'b1;
                    // chunk empties once everything handed out came back
                    if (new_fr == new_cur)
                    begin
                        cur_wdata = '0;
                        fr_wdata  = '0;
                    end
                    else
                    begin
                        cur_wdata = new_cur;
                        fr_wdata  = new_fr;
                    end
                    rsp_next = '{alloc_addr: '0, status: cba_pkg::ST_OK};
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            open_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            open_reg  <= open_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_open_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(open_reg) <= 32'(cba_pkg::MAX_CHUNKS))
        else $error("open chunk count beyond capacity");

    a_srch_has_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> (open_reg != '0) && (32'(k_reg) < 32'(open_reg)))
        else $error("search index outside open chunks");

    a_write_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        cur_we |=> done_reg && (state_reg == S_IDLE))
        else $error("table write without a result");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !pop)
        else $error("queue popped during a request");

endmodule

FILE: hw/rtl/chunked_bump_allocator.sv
// channel   dir  handshake                   payload
// request   in   start & !busy               req  (operation, req_size, free_addr)
// result    out  done, one cycle             rsp  (alloc_addr, status)
// config    in   cfg_valid & cfg_ready       cfg_data (chunk_bytes, 17 bits)
//
// A request rejected for size, or a free of an unopened chunk: the result is registered
// straight from the command the queue hands over. Allocate: the cursor table is scanned one
// entry per cycle from the newest open chunk down, then a chunk is opened (or none is left)
// if none had room. A free that maps to an open chunk: table read, update, then result.
// Reset clears the open count; table entries are written when a chunk opens.
// busy is high while the two-entry command queue is full; results cannot be held off.
module chunked_bump_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  cba_pkg::req_t               req,
    output logic                        done,
    output cba_pkg::rsp_t               rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cba_pkg::BYTES_W-1:0] cfg_data
);

    cba_pkg::fifo_stat_t         fstat;
    cba_pkg::cmd_t               push_cmd;
    cba_pkg::cmd_t               pop_cmd;
    logic                        push;
    logic                        pop;
    logic [cba_pkg::BYTES_W-1:0] csize;

    cba_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fstat     (fstat),
        .push      (push),
        .push_cmd  (push_cmd),
        .csize     (csize)
    );

    cba_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .fstat    (fstat)
    );

    cba_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .csize (csize),
        .cmd   (pop_cmd),
        .fstat (fstat),
        .pop   (pop),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import cba_pkg::*;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam int N_ROWS     = 31;
    localparam int N_PHASES   = 9;
    localparam int PHASE_REQS = 55;
    localparam int SETTLE_CYC = 24;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e          kind;
        logic               operation;
        logic [SIZE_W-1:0]  size;
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] cfg;
        bit                 chk;
        logic [ADDR_W-1:0]  exp_addr;
        logic [1:0]         exp_st;
    } vector_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] len;
    } block_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    req_t               req;
    logic               done;
    rsp_t               rsp;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [BYTES_W-1:0] cfg_data;

    // shadow of the arena
    logic [BYTES_W-1:0] chunk_cfg;
    int                 open_cnt;
    logic [BYTES_W-1:0] cur_tbl [MAX_CHUNKS];
    logic [BYTES_W-1:0] freed_tbl [MAX_CHUNKS];

    rsp_t   pending_rsp [$];
    block_t live_blocks [$];

    int fail_cnt;
    int req_cnt;
    int cfg_cnt;
    int status_seen [4];
    bit back_to_back;

    vector_t dir_tbl [N_ROWS] = '{
        '{ROW_REQ, OP_ALLOC, 16'd0,      20'h00000, 17'd0, 1'b1, 20'h0,  ST_BAD_SIZE},
        '{ROW_REQ, OP_FREE,  16'd0,      20'h00000, 17'd0, 1'b1, 20'h0,  ST_BAD_SIZE},
        '{ROW_REQ, OP_ALLOC, 16'd2048,   20'h00000, 17'd0, 1'b1, 20'h0,  ST_BAD_SIZE},
        '{ROW_REQ, OP_FREE,  16'd16,     20'h00000, 17'd0, 1'b1, 20'h0,  ST_NOT_FOUND},
        '{ROW_REQ, OP_ALLOC, 16'd16,     20'h00000, 17'd0, 1'b1, 20'h0,  ST_OK},
        '{ROW_REQ, OP_ALLOC, 16'd2047,   20'h00000, 17'd0, 1'b1, 20'h10, ST_OK},
        '{ROW_REQ, OP_ALLOC, 16'd2047,   20'h00000, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_FREE,  16'd2047,   20'h10000, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_FREE,  16'd2047,   20'h00010, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_FREE,  16'd16,     20'h00000, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_FREE,  16'd16,     20'h00000, 17'd0, 1'b1, 20'h0,  ST_NOT_FOUND},
        '{ROW_REQ, OP_ALLOC, 16'd1,      20'h00000, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_ALLOC, 16'd2047,   20'h00000, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_FREE,  16'd1,      20'h10000, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_FREE,  16'd2047,   20'h10001, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_FREE,  16'hFFFF,   20'hFFFFF, 17'd0, 1'b1, 20'h0,  ST_BAD_SIZE},
        '{ROW_CFG, OP_ALLOC, 16'd0,      20'h00000, 17'd1, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_ALLOC, 16'd1,      20'h00000, 17'd0, 1'b1, 20'h0,  ST_BAD_SIZE},
        '{ROW_CFG, OP_ALLOC, 16'd0,      20'h00000, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_FREE,  16'd1,      20'h00000, 17'd0, 1'b1, 20'h0,  ST_BAD_SIZE},
        '{ROW_CFG, OP_ALLOC, 16'd0,      20'h00000, 17'h1FFFF, 1'b0, 20'h0, ST_OK},
        '{ROW_REQ, OP_ALLOC, 16'd32767,  20'h00000, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_ALLOC, 16'd32768,  20'h00000, 17'd0, 1'b1, 20'h0,  ST_BAD_SIZE},
        '{ROW_REQ, OP_ALLOC, 16'd100,    20'h00000, 17'd0, 1'b0, 20'h0,  ST_OK},
        // hammer a non-last block until the freed count pins at its ceiling
        '{ROW_REQ, OP_FREE,  16'd32767,  20'h10000, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_FREE,  16'd32767,  20'h10000, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_FREE,  16'd32767,  20'h10000, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_FREE,  16'd32767,  20'h10000, 17'd0, 1'b0, 20'h0,  ST_OK},
        '{ROW_REQ, OP_FREE,  16'd32767,  20'h10000, 17'd0, 1'b0, 20'h0,  ST_OK},
        // chunk 1 now sits past the chunk size and must be skipped
        '{ROW_CFG, OP_ALLOC, 16'd0,      20'h00000, 17'd4096, 1'b0, 20'h0, ST_OK},
        '{ROW_REQ, OP_ALLOC, 16'd16,     20'h00000, 17'd0, 1'b0, 20'h0,  ST_OK}
    };

    int unsigned phase_bytes [N_PHASES] = '{4096, 65536, 8, 300, 131071, 2, 1000, 40, 4096};
    int          phase_alloc [N_PHASES] = '{50, 50, 90, 50, 55, 50, 45, 60, 50};

    chunked_bump_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned arena_size();
        return (chunk_cfg > CHUNK_LIMIT) ? 65536 : 32'(chunk_cfg);
    endfunction

    function automatic rsp_t model_request(req_t r);
        rsp_t        o;
        int unsigned csize;
        int unsigned c;
        int unsigned off;
        int unsigned sum;
        int          k;
        bit          hit;
        o = '0;
        csize = arena_size();
        hit = 1'b0;
        c = 0;
        if (r.req_size == 0 || r.req_size >= csize / 2)
        begin
            o.status = ST_BAD_SIZE;
        end
        else if (r.operation == OP_ALLOC)
        begin
            // newest chunk first
            for (k = open_cnt - 1; k >= 0; k--)
            begin
                if (!hit && cur_tbl[k] < csize && csize - cur_tbl[k] >= r.req_size)
                begin
                    c = k;
                    hit = 1'b1;
                end
            end
            if (!hit)
            begin
                if (open_cnt >= MAX_CHUNKS)
                begin
                    o.status = ST_NO_CHUNK;
                end
                else
                begin
                    c = open_cnt;
                    open_cnt++;
                    cur_tbl[c] = '0;
                    freed_tbl[c] = '0;
                    hit = 1'b1;
                end
            end
            if (hit)
            begin
                o.alloc_addr = ADDR_W'((c << 16) + cur_tbl[c]);
                cur_tbl[c] = cur_tbl[c] + r.req_size;
            end
        end
        else
        begin
            c = 32'(r.free_addr[19:16]);
            off = 32'(r.free_addr[15:0]);
            if (c >= open_cnt || off >= cur_tbl[c])
            begin
                o.status = ST_NOT_FOUND;
            end
            else
            begin
                if (r.req_size <= cur_tbl[c] && cur_tbl[c] - r.req_size == off)
                begin
                    cur_tbl[c] = cur_tbl[c] - r.req_size;
                end
                else
                begin
                    sum = freed_tbl[c] + r.req_size;
                    freed_tbl[c] = (sum > 17'h1FFFF) ? 17'h1FFFF : BYTES_W'(sum);
                end
                if (freed_tbl[c] == cur_tbl[c])
                begin
                    cur_tbl[c] = '0;
                    freed_tbl[c] = '0;
                end
            end
        end
        return o;
    endfunction

    // mostly well-formed alloc/free traffic against live blocks, some junk
    function automatic req_t next_request(int alloc_pct);
        req_t        r;
        int unsigned half;
        int unsigned top;
        int unsigned idx;
        int unsigned roll;
        r = '0;
        half = arena_size() / 2;
        roll = $urandom_range(0, 99);
        r.free_addr = ADDR_W'($urandom);
        if (roll < 8)
        begin
            r.operation = 1'($urandom);
            r.req_size = SIZE_W'($urandom);
        end
        else if (roll < 12 && live_blocks.size() > 0)
        begin
            // free that may be broken: interior address or wrong length
            idx = $urandom_range(0, live_blocks.size() - 1);
            r.operation = OP_FREE;
            r.free_addr = ADDR_W'(live_blocks[idx].addr + $urandom_range(0, 1));
            r.req_size = SIZE_W'(live_blocks[idx].len + $urandom_range(0, 2));
        end
        else if (live_blocks.size() == 0 || $urandom_range(0, 99) < alloc_pct)
        begin
            r.operation = OP_ALLOC;
            if (half <= 1)
            begin
                r.req_size = SIZE_W'($urandom_range(1, 3));
            end
            else
            begin
                top = half - 1;
                if ($urandom_range(0, 9) < 7 && top > 64)
                    top = 64;
                r.req_size = SIZE_W'($urandom_range(1, top));
            end
        end
        else
        begin
            if ($urandom_range(0, 1))
                idx = live_blocks.size() - 1;
            else
                idx = $urandom_range(0, live_blocks.size() - 1);
            r.operation = OP_FREE;
            r.free_addr = live_blocks[idx].addr;
            r.req_size = live_blocks[idx].len;
        end
        return r;
    endfunction

    task automatic issue(req_t r, bit typed, rsp_t typed_rsp);
        rsp_t got;
        int   gap;
        int   i;
        int   ch;
        bit   gone;
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        got = model_request(r);
        pending_rsp.push_back(typed ? typed_rsp : got);
        req_cnt++;
        if (got.status == ST_OK && r.operation == OP_ALLOC)
            live_blocks.push_back('{got.alloc_addr, r.req_size});
        gone = 1'b0;
        if (got.status == ST_OK && r.operation == OP_FREE)
        begin
            for (i = 0; i < live_blocks.size(); i++)
            begin
                if (!gone && live_blocks[i].addr == r.free_addr)
                begin
                    live_blocks.delete(i);
                    gone = 1'b1;
                end
            end
        end
        // drop blocks that a cursor rollback or chunk reset has swallowed
        for (i = live_blocks.size() - 1; i >= 0; i--)
        begin
            ch = 32'(live_blocks[i].addr[19:16]);
            if (ch >= open_cnt || live_blocks[i].addr[15:0] >= cur_tbl[ch])
                live_blocks.delete(i);
        end
        if ($urandom_range(0, 11) == 0)
            back_to_back = !back_to_back;
        gap = back_to_back ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_chunk_bytes(logic [BYTES_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        chunk_cfg = v;
        cfg_cnt++;
    endtask

    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && done)
        begin
            if (!$isunknown(rsp.status))
                status_seen[rsp.status]++;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result addr=%h status=%0d",
                         $time, rsp.alloc_addr, rsp.status);
                fail_cnt++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.alloc_addr !== want.alloc_addr)
                begin
                    $display("%0t: alloc_addr mismatch expected %h actual %h",
                             $time, want.alloc_addr, rsp.alloc_addr);
                    fail_cnt++;
                end
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, rsp.status);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", pending_rsp.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        vector_t row;
        req_t    r;
        rsp_t    typed;
        int      p;
        int      n;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = CHUNK_RESET;
        chunk_cfg = CHUNK_RESET;
        open_cnt = 0;
        foreach (cur_tbl[i])
        begin
            cur_tbl[i] = '0;
            freed_tbl[i] = '0;
        end
        fail_cnt = 0;
        req_cnt = 0;
        cfg_cnt = 0;
        back_to_back = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        foreach (dir_tbl[i])
        begin
            row = dir_tbl[i];
            if (row.kind == ROW_CFG)
            begin
                settle();
                write_chunk_bytes(row.cfg);
            end
            else
            begin
                r.operation = row.operation;
                r.req_size = row.size;
                r.free_addr = row.addr;
                typed.alloc_addr = row.exp_addr;
                typed.status = row.exp_st;
                issue(r, row.chk, typed);
            end
        end

        for (p = 0; p < N_PHASES; p++)
        begin
            settle();
            write_chunk_bytes(BYTES_W'(phase_bytes[p]));
            for (n = 0; n < PHASE_REQS; n++)
            begin
                // occasionally hold off until the block has gone quiet
                if ($urandom_range(0, 39) == 0)
                    settle();
                issue(next_request(phase_alloc[p]), 1'b0, '0);
            end
        end

        settle();
        $display("Covered %0d requests across %0d chunk-size writes, directed corners then",
                 req_cnt, cfg_cnt);
        $display("random alloc/free traffic: %0d ok, %0d bad size, %0d no chunk, %0d not found",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/cba_pkg.sv
hw/rtl/cba_ram.sv
hw/rtl/cba_front.sv
hw/rtl/cba_cmd_fifo.sv
hw/rtl/cba_back.sv
hw/rtl/chunked_bump_allocator.sv
test/tb.sv
